// ===== hw/rtl/mnpe_pkg.sv =====
package mnpe_pkg;

  // Storage layout: one error word followed by three ten-term polynomials.
  localparam int unsigned WORDS_PER_PIXEL = 31;
  localparam int unsigned TERMS           = 10;
  localparam int unsigned COEF_W          = 32;

  // Internal widths, sized for a search radius of up to 31.
  localparam int unsigned OFS_W  = 6;   // signed window offset
  localparam int unsigned D2_W   = 11;  // squared distance, at most 1922
  localparam int unsigned ROOT_W = 22;  // Q.16 distance
  localparam int unsigned FACT_W = 24;  // weight factor, kept with a sign bit
  localparam int unsigned COST_W = 57;  // error times factor, Q.32
  localparam int unsigned BEST_W = 25;  // integer part of the best cost
  localparam int unsigned MONO_W = 16;  // signed monomial up to 31 cubed
  localparam int unsigned PROD_W = MONO_W + COEF_W;
  localparam int unsigned ACC_W  = 52;

  localparam int START_BEST = 9999;
  localparam int COLOUR_MAX = 255;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEMERIT  = 2'd3;

  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  typedef struct packed {
    logic            start;
    logic [D2_W-1:0] d2;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

// ===== hw/rtl/mnpe_store.sv =====
module mnpe_store #(
  parameter int unsigned DEPTH = 126976,
  parameter int unsigned AW    = 17
) (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0] rdata_o
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/mnpe_isqrt.sv =====
module mnpe_isqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mnpe_pkg::sqrt_req_t  req_i,
  output mnpe_pkg::sqrt_rsp_t  rsp_o
);
  import mnpe_pkg::*;

  // Digit-recurrence root of d2 * 2^32, one result bit per cycle.
  logic [2*ROOT_W-1:0] rad_q, rad_d;
  logic [ROOT_W+3:0]   rem_q, rem_d, rem_sh, trial;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [4:0]          cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;

  assign rem_sh = {rem_q[ROOT_W+1:0], rad_q[2*ROOT_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rad_d  = {1'b0, req_i.d2, 32'b0};
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[2*ROOT_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(ROOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

// ===== hw/rtl/min_error_neighbour_poly_eval_core.sv =====
// Channel   Direction  Handshake             Contents
// s_axis    in         tvalid/tready         tuser: req_type; tdata: pixel, index, value
// m_axis    out        tvalid/tready         tdata: red, green, blue, offset_x, offset_y
// cfg       in         cfg_valid/cfg_ready   cfg_index selects one of four registers
//
// A write word is stored while the block is idle. A compute word scans the window one
// offset per cycle while it lies outside the circle or the image; an offset inside goes
// through the read step, the 22-step bit-serial distance root and the factor, cost and
// compare steps. Evaluation then takes two monomial steps and reads the 30 coefficients
// through the single read port with a two-stage pipeline, and then loads the result
// register. Reset clears all control state; the coefficient memory is not cleared and
// must be written before it is read. A result waiting on m_axis stalls only the end of
// the next compute word; write words pass meanwhile.
module min_error_neighbour_poly_eval_core #(
  parameter int unsigned MAX_WIDTH         = 64,
  parameter int unsigned MAX_HEIGHT        = 64,
  parameter int unsigned MAX_SEARCH_RADIUS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: pixel_x[5:0], pixel_y[11:6], coef_index[16:12], coef_value[48:17]
  input  logic [55:0] s_axis_tdata_i,
  // tuser: req_type[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: red[7:0], green[15:8], blue[23:16], offset_x[28:24], offset_y[33:29]
  output logic [39:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [mnpe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import mnpe_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT * WORDS_PER_PIXEL;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SCAN  = 4'd1;
  localparam logic [3:0] ST_RDERR = 4'd2;
  localparam logic [3:0] ST_WAIT  = 4'd3;
  localparam logic [3:0] ST_FACT  = 4'd4;
  localparam logic [3:0] ST_COST  = 4'd5;
  localparam logic [3:0] ST_CMP   = 4'd6;
  localparam logic [3:0] ST_MONO1 = 4'd7;
  localparam logic [3:0] ST_MONO2 = 4'd8;
  localparam logic [3:0] ST_EVAL  = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  function automatic logic [AW-1:0] pix_base(input logic [6:0] x, input logic [6:0] y);
    logic [AW-1:0] idx;
    idx = AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    return AW'(idx * AW'(WORDS_PER_PIXEL));
  endfunction

  // Configuration registers.
  logic [6:0]  width_q, height_q;
  logic [3:0]  radius_q;
  logic [15:0] demerit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 7'd64;
      height_q  <= 7'd64;
      radius_q  <= 4'd2;
      demerit_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIDTH:   width_q   <= cfg_data_i[6:0];
        CFG_HEIGHT:  height_q  <= cfg_data_i[6:0];
        CFG_RADIUS:  radius_q  <= cfg_data_i[3:0];
        CFG_DEMERIT: demerit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input fields.
  logic        in_req;
  logic [5:0]  in_px, in_py;
  logic [4:0]  in_ci;
  logic [31:0] in_val;
  logic        in_acc;

  assign in_req = s_axis_tuser_i;
  assign in_px  = s_axis_tdata_i[5:0];
  assign in_py  = s_axis_tdata_i[11:6];
  assign in_ci  = s_axis_tdata_i[16:12];
  assign in_val = s_axis_tdata_i[48:17];

  logic [3:0] state_q, state_d;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  logic in_store;
  assign in_store = (int'(in_px) < MAX_WIDTH) && (int'(in_py) < MAX_HEIGHT);

  // Saturated working limits.
  logic [10:0] w_lim, h_lim;
  logic [4:0]  rad;
  assign w_lim = (int'(width_q) > MAX_WIDTH) ? 11'(MAX_WIDTH) : 11'(width_q);
  assign h_lim = (int'(height_q) > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : 11'(height_q);
  assign rad   = (int'(radius_q) > MAX_SEARCH_RADIUS) ? 5'(MAX_SEARCH_RADIUS)
                                                      : {1'b0, radius_q};

  // Scan and selection state.
  logic [5:0]               px_q, py_q;
  logic signed [OFS_W-1:0]  dx_q, dx_d, dy_q, dy_d, bx_q, bx_d, by_q, by_d;
  logic [AW-1:0]            win_q, win_d, nb_q, nb_d;
  logic signed [BEST_W-1:0] best_q, best_d;
  logic signed [COEF_W-1:0] err_q;
  logic signed [FACT_W-1:0] factor_q;
  logic signed [COST_W-1:0] cost_q;

  logic signed [OFS_W-1:0] rad_s;
  logic signed [11:0] sqx, sqy, nx, ny;
  logic [D2_W-1:0] d2;
  logic [9:0]      rr;
  logic            take, last_off;
  logic [AW-1:0]   nb_addr;

  assign rad_s = $signed({1'b0, rad});
  assign sqx   = 12'(dx_q * dx_q);
  assign sqy   = 12'(dy_q * dy_q);
  assign d2    = D2_W'(sqx + sqy);
  assign rr    = 10'(rad * rad);
  assign nx    = $signed({6'b0, px_q}) + {{(12-OFS_W){dx_q[OFS_W-1]}}, dx_q};
  assign ny    = $signed({6'b0, py_q}) + {{(12-OFS_W){dy_q[OFS_W-1]}}, dy_q};
  assign take  = (12'(d2) < 12'(rr)) && !nx[11] && !ny[11]
                 && (nx < $signed({1'b0, w_lim})) && (ny < $signed({1'b0, h_lim}));
  assign last_off = (dx_q == rad_s) && (dy_q == rad_s);
  assign nb_addr  = pix_base(nx[6:0], ny[6:0]);

  // Distance root unit.
  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;
  assign sq_req.start = (state_q == ST_SCAN) && take;
  assign sq_req.d2    = d2;

  mnpe_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .rsp_o  (sq_rsp)
  );

  // Cost comparison against the integer best, scaled by 2^32.
  logic signed [COST_W:0] cost_x, best_x, cost_neg;
  logic beats;
  logic [ROOT_W+15:0] dem_prod;
  assign cost_x   = {cost_q[COST_W-1], cost_q};
  assign best_x   = {best_q[BEST_W-1], best_q, 32'b0};
  assign beats    = cost_x < best_x;
  assign cost_neg = -cost_x;
  assign dem_prod = demerit_q * sq_rsp.root;

  // Monomials of the winning offset.
  logic signed [MONO_W-1:0] mx_q, my_q, mxx_q, mxy_q, myy_q;
  logic signed [MONO_W-1:0] mxxx_q, mxxy_q, mxyy_q, myyy_q;

  // Evaluation pipeline: issue, read data, product, accumulate.
  logic [3:0] j_q, j_d, j1_q, j2_q;
  logic [1:0] ch_q, ch_d, ch1_q, ch2_q;
  logic       iss_q, iss_d, v1_q, v2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_sum, acc_rnd;
  logic signed [MONO_W-1:0] mono;
  logic [7:0] col_q [3];
  logic [7:0] col_fin;
  logic [AW-1:0] ev_addr;

  assign ev_addr = win_q + AW'(1) + AW'(ch_q) * AW'(TERMS) + AW'(j_q);

  always_comb begin
    case (j1_q)
      4'd0:    mono = MONO_W'(1);
      4'd1:    mono = mx_q;
      4'd2:    mono = my_q;
      4'd3:    mono = mxx_q;
      4'd4:    mono = mxy_q;
      4'd5:    mono = myy_q;
      4'd6:    mono = mxxx_q;
      4'd7:    mono = mxxy_q;
      4'd8:    mono = mxyy_q;
      4'd9:    mono = myyy_q;
      default: mono = '0;
    endcase
  end

  // The constant term is added, every other term subtracted.
  always_comb begin
    if (j2_q == 4'd0) begin
      acc_sum = ACC_W'(prod_q);
    end else begin
      acc_sum = acc_q - ACC_W'(prod_q);
    end
    acc_rnd = (acc_sum + ACC_W'(32768)) >>> 16;
    if (acc_sum[ACC_W-1]) begin
      col_fin = '0;
    end else if (acc_rnd > ACC_W'(COLOUR_MAX)) begin
      col_fin = 8'(COLOUR_MAX);
    end else begin
      col_fin = acc_rnd[7:0];
    end
  end

  // Memory.
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_rdata;

  // Writes happen only while idle and every read is issued later, so accesses
  // to one entry never overlap.
  assign mem_we    = in_acc && (in_req == REQ_WRITE) && in_store
                     && (int'(in_ci) < WORDS_PER_PIXEL);
  assign mem_waddr = pix_base({1'b0, in_px}, {1'b0, in_py}) + AW'(in_ci);
  assign mem_raddr = (state_q == ST_EVAL) ? ev_addr : nb_addr;

  mnpe_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_val),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register.
  logic out_valid_q, out_valid_d, out_load;
  logic [39:0] out_data_q;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    bx_d    = bx_q;
    by_d    = by_q;
    win_d   = win_q;
    nb_d    = nb_q;
    best_d  = best_q;
    j_d     = j_q;
    ch_d    = ch_q;
    iss_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_req == REQ_COMPUTE)) begin
          dx_d   = -rad_s;
          dy_d   = -rad_s;
          bx_d   = '0;
          by_d   = '0;
          best_d = BEST_W'(START_BEST);
          win_d  = pix_base({1'b0, in_px}, {1'b0, in_py});
          state_d = in_store ? ST_SCAN : ST_OUT;
        end
      end
      ST_SCAN, ST_CMP: begin
        if ((state_q == ST_SCAN) && take) begin
          nb_d    = nb_addr;
          state_d = ST_RDERR;
        end else begin
          if ((state_q == ST_CMP) && beats) begin
            best_d = cost_q[COST_W-1] ? -cost_neg[COST_W-1:32] : cost_q[COST_W-1:32];
            win_d  = nb_q;
            bx_d   = dx_q;
            by_d   = dy_q;
          end
          if (last_off) begin
            state_d = ST_MONO1;
          end else begin
            state_d = ST_SCAN;
            if (dx_q == rad_s) begin
              dx_d = -rad_s;
              dy_d = dy_q + OFS_W'(1);
            end else begin
              dx_d = dx_q + OFS_W'(1);
            end
          end
        end
      end
      ST_RDERR: state_d = ST_WAIT;
      ST_WAIT: begin
        if (sq_rsp.done) begin
          state_d = ST_FACT;
        end
      end
      ST_FACT:  state_d = ST_COST;
      ST_COST:  state_d = ST_CMP;
      ST_MONO1: state_d = ST_MONO2;
      ST_MONO2: begin
        j_d     = '0;
        ch_d    = '0;
        iss_d   = 1'b1;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (iss_q) begin
          if (j_q == 4'(TERMS - 1)) begin
            j_d   = '0;
            ch_d  = ch_q + 2'd1;
            iss_d = (ch_q != 2'd2);
          end else begin
            j_d   = j_q + 4'd1;
            iss_d = 1'b1;
          end
        end
        if (v2_q && (j2_q == 4'(TERMS - 1)) && (ch2_q == 2'd2)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      iss_q       <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      iss_q       <= iss_d;
      v1_q        <= iss_q && (state_q == ST_EVAL);
      v2_q        <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    bx_q   <= bx_d;
    by_q   <= by_d;
    win_q  <= win_d;
    nb_q   <= nb_d;
    best_q <= best_d;
    j_q    <= j_d;
    ch_q   <= ch_d;
    j1_q   <= j_q;
    ch1_q  <= ch_q;
    j2_q   <= j1_q;
    ch2_q  <= ch1_q;
    if (in_acc) begin
      px_q <= in_px;
      py_q <= in_py;
    end
    if (state_q == ST_RDERR) begin
      err_q <= $signed(mem_rdata);
    end
    if (state_q == ST_FACT) begin
      factor_q <= FACT_W'(32'd65536 + 32'(dem_prod >> 16));
    end
    if (state_q == ST_COST) begin
      cost_q <= COST_W'(err_q * factor_q);
    end
    if (state_q == ST_MONO1) begin
      mx_q  <= MONO_W'(bx_q);
      my_q  <= MONO_W'(by_q);
      mxx_q <= MONO_W'(bx_q * bx_q);
      mxy_q <= MONO_W'(bx_q * by_q);
      myy_q <= MONO_W'(by_q * by_q);
    end
    if (state_q == ST_MONO2) begin
      mxxx_q <= MONO_W'(mxx_q * mx_q);
      mxxy_q <= MONO_W'(mxx_q * my_q);
      mxyy_q <= MONO_W'(myy_q * mx_q);
      myyy_q <= MONO_W'(myy_q * my_q);
    end
    prod_q <= PROD_W'(mono * $signed(mem_rdata));
    if (v2_q) begin
      acc_q <= acc_sum;
      if (j2_q == 4'(TERMS - 1)) begin
        col_q[ch2_q] <= col_fin;
      end
    end
    if (in_acc && (in_req == REQ_COMPUTE) && !in_store) begin
      col_q[0] <= '0;
      col_q[1] <= '0;
      col_q[2] <= '0;
    end
    if (out_load) begin
      out_data_q <= {6'b0, by_q[4:0], bx_q[4:0], col_q[2], col_q[1], col_q[0]};
    end
  end

  // The evaluation pipeline is empty whenever a new word can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!v1_q && !v2_q && !iss_q))
    else $error("evaluation pipeline busy while idle");

  // A root only completes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_rsp.done |-> (state_q == ST_WAIT))
    else $error("distance root finished outside the wait step");

  // The best cost never rises above its starting value during a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_CMP) |-> (best_q <= BEST_W'(START_BEST)))
    else $error("best cost above start value");

  // A result is loaded only from the output step, which then returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("result load did not complete");

endmodule

// ===== tb/tb_min_error_neighbour_poly_eval_core.sv =====
`timescale 1ns / 100ps

module tb_min_error_neighbour_poly_eval_core;
  import mnpe_pkg::*;

  localparam int MAX_W     = 64;
  localparam int MAX_H     = 64;
  localparam int MAX_R     = 15;
  localparam int WORDS     = 31;
  // Compute words and most writes use this square of pixels; every scan stays inside it.
  localparam int REGION    = 4;
  localparam int DRAIN_CYC = 80;

  typedef struct packed {
    logic        req;
    logic [5:0]  px;
    logic [5:0]  py;
    logic [4:0]  idx;
    logic [31:0] value;
  } req_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [4:0] ofs_x;
    logic [4:0] ofs_y;
  } target_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
  logic [15:0] cfg_data = '0;

  req_word_t cur_word = '0;
  req_word_t pending_words[$];
  target_t   target_q[$];
  bit        quiet = 1'b0;
  int        fail_count = 0;

  // Shadow copy of the block's coefficient memory and registers.
  bit [31:0] coef_mem [0:MAX_W*MAX_H*WORDS-1];
  int        shadow_width  = 64;
  int        shadow_height = 64;
  int        shadow_radius = 2;
  longint    shadow_demerit = 0;

  // tdata: pixel_x[5:0], pixel_y[11:6], coef_index[16:12], coef_value[48:17]
  assign s_tdata = {7'b0, cur_word.value, cur_word.idx, cur_word.py, cur_word.px};
  // tuser: req_type[0]
  assign s_tuser = cur_word.req;

  always #1 clk_i = ~clk_i;

  min_error_neighbour_poly_eval_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Bit-serial integer square root, floor of sqrt(n).
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint coef_at(int addr);
    return longint'($signed(coef_mem[addr]));
  endfunction

  // One colour channel of the winner: the constant term minus every other term at the offset.
  function automatic logic [7:0] eval_colour(int base, longint bx, longint by, int ch);
    longint mono[10];
    longint sum;
    int first;
    first   = base + 1 + 10 * ch;
    mono[0] = 1;
    mono[1] = bx;
    mono[2] = by;
    mono[3] = bx * bx;
    mono[4] = bx * by;
    mono[5] = by * by;
    mono[6] = bx * bx * bx;
    mono[7] = bx * bx * by;
    mono[8] = bx * by * by;
    mono[9] = by * by * by;
    sum = coef_at(first);
    for (int i = 1; i < 10; i++) sum = sum - mono[i] * coef_at(first + i);
    if (sum < 0) return 8'd0;
    sum = (sum + 32768) >>> 16;
    if (sum > COLOUR_MAX) return 8'(COLOUR_MAX);
    return 8'(sum);
  endfunction

  // Window scan: a neighbour wins when its weighted error is below the running best.
  function automatic target_t predict_target(int px, int py);
    target_t t;
    int w, h, rad, nx, ny, d2, addr, win;
    longint best, bx, by, cost;
    longint unsigned root_dist, factor;
    w    = (shadow_width  > MAX_W) ? MAX_W : shadow_width;
    h    = (shadow_height > MAX_H) ? MAX_H : shadow_height;
    rad  = (shadow_radius > MAX_R) ? MAX_R : shadow_radius;
    best = START_BEST;
    bx   = 0;
    by   = 0;
    win  = (py * MAX_W + px) * WORDS;
    for (int dy = -rad; dy <= rad; dy++) begin
      for (int dx = -rad; dx <= rad; dx++) begin
        nx = px + dx;
        ny = py + dy;
        d2 = dx * dx + dy * dy;
        if (d2 >= rad * rad) continue;
        if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
        root_dist = int_sqrt(longint'(d2) << 32);
        factor    = 65536 + ((longint'(shadow_demerit) * root_dist) >> 16);
        addr      = (ny * MAX_W + nx) * WORDS;
        cost      = coef_at(addr) * longint'(factor);
        if (cost < best * 64'sd4294967296) begin
          // The running best keeps only the integer part, truncated toward zero.
          if (cost < 0) best = -longint'(longint'(-cost) >> 32);
          else best = cost >> 32;
          win = addr;
          bx  = dx;
          by  = dy;
        end
      end
    end
    t.red   = eval_colour(win, bx, by, 0);
    t.green = eval_colour(win, bx, by, 1);
    t.blue  = eval_colour(win, bx, by, 2);
    t.ofs_x = 5'(bx);
    t.ofs_y = 5'(by);
    return t;
  endfunction

  // Applies one accepted word to the shadow state or queues its result.
  function automatic void apply_word(req_word_t wd);
    if (wd.req == REQ_WRITE) begin
      if (wd.idx < WORDS)
        coef_mem[(int'(wd.py) * MAX_W + int'(wd.px)) * WORDS + wd.idx] = wd.value;
    end else begin
      target_q.push_back(predict_target(wd.px, wd.py));
    end
  endfunction

  // Driver: a new word is offered only when the previous one has gone.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) apply_word(cur_word);
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() > 0 && (quiet || $urandom_range(0, 99) >= 11)) begin
          cur_word <= pending_words.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result word with the oldest prediction.
  always @(posedge clk_i) begin
    target_t got, want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        // tdata: red[7:0], green[15:8], blue[23:16], offset_x[28:24], offset_y[33:29]
        got.red   = m_tdata[7:0];
        got.green = m_tdata[15:8];
        got.blue  = m_tdata[23:16];
        got.ofs_x = m_tdata[28:24];
        got.ofs_y = m_tdata[33:29];
        if (target_q.size() == 0) begin
          $error("unexpected result word %h", m_tdata);
          fail_count++;
        end else begin
          want = target_q.pop_front();
          if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            fail_count++;
          end
          if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            fail_count++;
          end
          if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            fail_count++;
          end
          if (got.ofs_x !== want.ofs_x) begin
            $error("offset_x: expected %0d, got %0d", $signed(want.ofs_x), $signed(got.ofs_x));
            fail_count++;
          end
          if (got.ofs_y !== want.ofs_y) begin
            $error("offset_y: expected %0d, got %0d", $signed(want.ofs_y), $signed(got.ofs_y));
            fail_count++;
          end
        end
      end
      m_tready <= quiet || ($urandom_range(0, 99) >= 11);
    end
  end

  // Coefficient values: mostly in useful ranges, a quarter fully random.
  function automatic logic [31:0] coef_value(int idx);
    if ($urandom_range(0, 3) == 0) return $urandom;
    if (idx == 0) return 32'($signed($urandom_range(0, 24000)) - 12000) << 16 | $urandom_range(0, 65535);
    if (idx % 10 == 1) return 32'($urandom_range(0, 300 << 16));
    return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
  endfunction

  function automatic req_word_t write_word(int x, int y, int idx, logic [31:0] v);
    req_word_t wd;
    wd.req   = REQ_WRITE;
    wd.px    = 6'(x);
    wd.py    = 6'(y);
    wd.idx   = 5'(idx);
    wd.value = v;
    return wd;
  endfunction

  function automatic req_word_t compute_word(int x, int y);
    req_word_t wd;
    wd.req   = REQ_COMPUTE;
    wd.px    = 6'(x);
    wd.py    = 6'(y);
    wd.idx   = 5'($urandom);
    wd.value = $urandom;
    return wd;
  endfunction

  // Waits until the sender is empty and every result has come back.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || s_tvalid || target_q.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i);
    while (!cfg_ready);
    case (idx)
      CFG_WIDTH:   shadow_width   = value & 16'h7f;
      CFG_HEIGHT:  shadow_height  = value & 16'h7f;
      CFG_RADIUS:  shadow_radius  = value & 16'hf;
      CFG_DEMERIT: shadow_demerit = value;
      default: ;
    endcase
  endtask

  // Reprograms all four registers once the block has gone idle.
  task automatic set_config(int w, int h, int r, int dem);
    wait_idle();
    cfg_write(CFG_WIDTH, 16'(w));
    cfg_write(CFG_HEIGHT, 16'(h));
    cfg_write(CFG_RADIUS, 16'(r));
    cfg_write(CFG_DEMERIT, 16'(dem));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int r, w, h, dem, idx;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Load every word of the region, then hit three corners and an edge pixel.
    set_config(REGION, REGION, 2, 0);
    for (int y = 0; y < REGION; y++)
      for (int x = 0; x < REGION; x++)
        for (int i = 0; i < WORDS; i++) pending_words.push_back(write_word(x, y, i, coef_value(i)));
    pending_words.push_back(write_word(1, 1, 3, 32'h8000_0000));
    pending_words.push_back(write_word(1, 2, 4, 32'h7fff_ffff));
    pending_words.push_back(write_word(63, 63, 30, 32'hffff_ffff));
    pending_words.push_back(write_word(2, 2, 31, 32'h1234_5678));
    pending_words.push_back(compute_word(0, 0));
    pending_words.push_back(compute_word(3, 3));
    pending_words.push_back(compute_word(2, 3));
    pending_words.push_back(compute_word(3, 0));

    // Largest radius with the heaviest distance weight.
    set_config(REGION, REGION, 15, 65535);
    pending_words.push_back(compute_word(0, 0));
    pending_words.push_back(compute_word(3, 3));

    // An empty window always picks the pixel itself.
    set_config(REGION, REGION, 0, 1000);
    pending_words.push_back(compute_word(3, 1));

    // A zero-sized image leaves no neighbour inside.
    set_config(0, 0, 3, 100);
    pending_words.push_back(compute_word(2, 2));

    // Oversized width and height saturate; radius zero keeps reads in the region.
    set_config(127, 127, 0, 0);
    pending_words.push_back(compute_word(3, 3));
    set_config(64, 64, 0, 65535);
    pending_words.push_back(compute_word(0, 3));

    // No neighbour beats the starting best when every error is huge.
    set_config(REGION, REGION, 4, 0);
    for (int y = 0; y < REGION; y++)
      for (int x = 0; x < REGION; x++) pending_words.push_back(write_word(x, y, 0, 32'h7fff_ffff));
    pending_words.push_back(compute_word(2, 2));
    pending_words.push_back(compute_word(0, 3));

    // Random phases, one of them without any idling on either side.
    for (int ph = 0; ph < 8; ph++) begin
      r   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      w   = (r == 0) ? $urandom_range(0, 127) : $urandom_range(0, REGION);
      h   = (r == 0) ? $urandom_range(0, 127) : $urandom_range(0, REGION);
      case ($urandom_range(0, 3))
        0: dem = 0;
        1: dem = 65535;
        default: dem = $urandom_range(0, 65535);
      endcase
      set_config(w, h, r, dem);
      quiet = (ph == 4);
      for (int n = 0; n < 78; n++) begin
        if ($urandom_range(0, 99) < 45) begin
          if ($urandom_range(0, 99) < 85) begin
            idx = $urandom_range(0, 31);
            pending_words.push_back(write_word($urandom_range(0, REGION - 1),
                                               $urandom_range(0, REGION - 1), idx,
                                               coef_value(idx)));
          end else begin
            pending_words.push_back(write_word($urandom_range(0, 63), $urandom_range(0, 63),
                                               $urandom_range(0, 31), $urandom));
          end
        end else begin
          pending_words.push_back(compute_word($urandom_range(0, REGION - 1),
                                               $urandom_range(0, REGION - 1)));
        end
      end
      wait_idle();
      quiet = 1'b0;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("status: fail");
    $finish;
  end

endmodule
